[rtl/core/irfd_pkg.sv]
// Package with the shared types, constants and helpers of the IR remote frame decoder.
`default_nettype none
package irfd_pkg;

    localparam int TIMER_WIDTH = 16;
    localparam int CFG_WIDTH   = 16;
    localparam int CMP_WIDTH   = (TIMER_WIDTH > CFG_WIDTH) ? TIMER_WIDTH : CFG_WIDTH;
    localparam int CFG_IDX_W   = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_LEAD_MIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_MIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_MIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_END_GAP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD     = 3'd4;

    localparam logic [CFG_WIDTH-1:0] LEAD_MIN_RST = 16'd37;
    localparam logic [CFG_WIDTH-1:0] GAP_MIN_RST  = 16'd14;
    localparam logic [CFG_WIDTH-1:0] ONE_MIN_RST  = 16'd5;
    localparam logic [CFG_WIDTH-1:0] END_GAP_RST  = 16'd46;
    localparam logic [CFG_WIDTH-1:0] HOLD_RST     = 16'd1014;

    localparam logic [7:0] BIT_EDGE_AFTER = 8'd15;
    localparam logic [7:0] LATCH_EDGE     = 8'd24;
    localparam logic [7:0] ONE_BIT        = 8'h01;

    localparam logic LEVEL_MARK  = 1'b0;
    localparam logic LEVEL_SPACE = 1'b1;

    typedef logic [TIMER_WIDTH-1:0] t_timer;
    typedef logic [CFG_WIDTH-1:0]   t_cfg_word;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_LEAD = 2'd1,
        PH_READ = 2'd2
    } t_phase;

    typedef struct packed {
        t_cfg_word lead_min;
        t_cfg_word gap_min;
        t_cfg_word one_min;
        t_cfg_word end_gap;
        t_cfg_word hold;
    } t_cfg;

    typedef struct packed {
        logic [7:0] code;
        logic       code_done;
        t_phase     phase_now;
    } t_result;

    function automatic t_timer timer_advance(input t_timer t);
        return (t == {TIMER_WIDTH{1'b1}}) ? t : t + t_timer'(1);
    endfunction

    function automatic logic timer_gt(input t_timer t, input t_cfg_word c);
        return CMP_WIDTH'(t) > CMP_WIDTH'(c);
    endfunction

endpackage
`default_nettype wire

[rtl/core/irfd_cfg_regs.sv]
// Configuration register bank of the IR remote frame decoder.
`default_nettype none
module irfd_cfg_regs
    import irfd_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_WIDTH-1:0] i_cfg_wdata,
    output t_cfg                      o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lead_min <= LEAD_MIN_RST;
            r_cfg.gap_min  <= GAP_MIN_RST;
            r_cfg.one_min  <= ONE_MIN_RST;
            r_cfg.end_gap  <= END_GAP_RST;
            r_cfg.hold     <= HOLD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LEAD_MIN: r_cfg.lead_min <= i_cfg_wdata;
                CFG_GAP_MIN:  r_cfg.gap_min  <= i_cfg_wdata;
                CFG_ONE_MIN:  r_cfg.one_min  <= i_cfg_wdata;
                CFG_END_GAP:  r_cfg.end_gap  <= i_cfg_wdata;
                CFG_HOLD:     r_cfg.hold     <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

[rtl/core/irfd_core.sv]
// Decoder state and single-tick next-state logic of the IR remote frame decoder.
`default_nettype none
module irfd_core
    import irfd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_step,
    input  wire logic i_level,
    input  t_cfg      i_cfg,
    output t_result   o_result
);

    t_phase     r_phase, n_phase;
    logic       r_in_mark, n_in_mark;
    logic [7:0] r_edge_count, n_edge_count;
    logic [7:0] r_shift_byte, n_shift_byte;
    logic [7:0] r_held_code, n_held_code;
    t_timer     r_lead_el, n_lead_el;
    t_timer     r_space_el, n_space_el;
    t_timer     r_end_el, n_end_el;
    t_timer     r_hold_el, n_hold_el;
    logic       n_done;

    always_comb begin
        n_phase      = r_phase;
        n_in_mark    = r_in_mark;
        n_edge_count = r_edge_count;
        n_shift_byte = r_shift_byte;
        n_held_code  = r_held_code;
        n_lead_el    = timer_advance(r_lead_el);
        n_space_el   = timer_advance(r_space_el);
        n_end_el     = timer_advance(r_end_el);
        n_hold_el    = timer_advance(r_hold_el);
        n_done       = 1'b0;

        if (timer_gt(n_hold_el, i_cfg.hold)) begin
            n_hold_el    = '0;
            n_held_code  = '0;
            n_shift_byte = '0;
            n_edge_count = '0;
            n_phase      = PH_IDLE;
        end

        case (n_phase)
            PH_READ: begin
                if (timer_gt(n_end_el, i_cfg.end_gap)) begin
                    n_end_el     = '0;
                    n_hold_el    = '0;
                    n_shift_byte = '0;
                    n_edge_count = '0;
                    n_phase      = PH_IDLE;
                end else if (n_in_mark) begin
                    if (i_level == LEVEL_SPACE) begin
                        n_space_el = '0;
                        n_end_el   = '0;
                        n_in_mark  = 1'b0;
                    end
                end else if (i_level == LEVEL_MARK) begin
                    if (n_edge_count > BIT_EDGE_AFTER && n_edge_count < LATCH_EDGE) begin
                        n_shift_byte = {n_shift_byte[6:0], 1'b0};
                        if (timer_gt(n_space_el, i_cfg.one_min)) begin
                            n_space_el   = '0;
                            n_shift_byte = n_shift_byte | ONE_BIT;
                        end
                    end
                    n_edge_count = n_edge_count + 8'd1;
                    n_in_mark    = 1'b1;
                    if (n_edge_count == LATCH_EDGE) begin
                        n_held_code = n_shift_byte;
                        n_done      = 1'b1;
                    end
                end
            end
            PH_LEAD: begin
                if (i_level == LEVEL_MARK) begin
                    if (timer_gt(n_space_el, i_cfg.gap_min)) begin
                        n_phase    = PH_READ;
                        n_space_el = '0;
                        n_end_el   = '0;
                        n_in_mark  = 1'b1;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
            end
            PH_IDLE: begin
                if (!n_in_mark) begin
                    if (i_level == LEVEL_MARK) begin
                        n_in_mark = 1'b1;
                        n_lead_el = '0;
                    end
                end else if (i_level == LEVEL_SPACE) begin
                    n_in_mark = 1'b0;
                    if (timer_gt(n_lead_el, i_cfg.lead_min)) begin
                        n_lead_el  = '0;
                        n_phase    = PH_LEAD;
                        n_space_el = '0;
                    end
                end
            end
            default: begin
            end
        endcase

        o_result.code      = n_held_code;
        o_result.code_done = n_done;
        o_result.phase_now = n_phase;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_in_mark    <= 1'b0;
            r_edge_count <= '0;
            r_shift_byte <= '0;
            r_held_code  <= '0;
            r_lead_el    <= '0;
            r_space_el   <= '0;
            r_end_el     <= '0;
            r_hold_el    <= '0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_in_mark    <= n_in_mark;
            r_edge_count <= n_edge_count;
            r_shift_byte <= n_shift_byte;
            r_held_code  <= n_held_code;
            r_lead_el    <= n_lead_el;
            r_space_el   <= n_space_el;
            r_end_el     <= n_end_el;
            r_hold_el    <= n_hold_el;
        end
    end

endmodule
`default_nettype wire

[rtl/core/ir_remote_frame_decoder.sv]
// Top level of the IR remote frame decoder with stream ports and result register.
//
// Channel   Direction  Beat contents
// s_axis    in         one sampled receiver level per tick
// m_axis    out        held code, phase and new-code flag for that tick
// cfg       in         register write, index and 16-bit data
//
// Each input beat is decoded combinationally, and a new beat is taken every cycle while the input side is ready.
// The result beat appears in the cycle after its input beat is taken, from the result register.
// The input side stalls only while a result waits and the output side is not ready.
// Reset is synchronous and restores the default thresholds and the idle decoder.
`default_nettype none
module ir_remote_frame_decoder
    import irfd_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  wire logic [7:0]           i_s_axis_tdata,  // [0] ir_level
    output logic                      o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    output logic [15:0]               o_m_axis_tdata,  // [7:0] code, [9:8] phase_now
    output logic                      o_m_axis_tuser,  // [0] code_done
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_WIDTH-1:0] i_cfg_wdata
);

    t_cfg    w_cfg;
    t_result w_result;
    t_result r_result;
    logic    r_out_valid;
    logic    w_step;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_step          = i_s_axis_tvalid && o_s_axis_tready;

    irfd_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    irfd_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_level  (i_s_axis_tdata[0]),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_out_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_result <= w_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_result.phase_now, r_result.code};
    assign o_m_axis_tuser  = r_result.code_done;

endmodule
`default_nettype wire
